>>> rtl/kss_pkg.sv
// Shared types and constants for the six-axis scalar Kalman smoother.
// Holds the beat payload structs, the controller command and status structs
// and the register map. Depends on nothing else.
package kss_pkg;

   localparam int SAMPLE_W      = 16;
   localparam int NUM_FIELDS    = 6;
   localparam int REG_W         = 24;
   localparam int VAR_W         = 25;
   localparam int DEN_W         = 26;
   localparam int CSR_DATA_W    = 32;
   localparam int CSR_ADDR_W    = 3;
   localparam int DEF_AXES      = 6;
   localparam int DEF_FRAC_BITS = 16;

   localparam logic [REG_W-1:0] Q_RESET = REG_W'(655);
   localparam logic [REG_W-1:0] R_RESET = REG_W'(6554);

   typedef enum logic {
      REG_PROCESS_NOISE = 1'b0,
      REG_MEASURE_NOISE = 1'b1
   } kss_reg_index_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] accel_x;
      logic signed [SAMPLE_W-1:0] accel_y;
      logic signed [SAMPLE_W-1:0] accel_z;
      logic signed [SAMPLE_W-1:0] gyro_x;
      logic signed [SAMPLE_W-1:0] gyro_y;
      logic signed [SAMPLE_W-1:0] gyro_z;
   } kss_req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] est_accel_x;
      logic signed [SAMPLE_W-1:0] est_accel_y;
      logic signed [SAMPLE_W-1:0] est_accel_z;
      logic signed [SAMPLE_W-1:0] est_gyro_x;
      logic signed [SAMPLE_W-1:0] est_gyro_y;
      logic signed [SAMPLE_W-1:0] est_gyro_z;
   } kss_rsp_type;

   typedef struct packed {
      logic load;
      logic div_init;
      logic div_step;
      logic var_mul;
      logic var_wr;
      logic ax_diff;
      logic ax_mul_lo;
      logic ax_mul_hi;
      logic ax_acc;
      logic publish;
   } kss_cmd_type;

   typedef struct packed {
      logic out_free;
   } kss_status_type;

endpackage

>>> rtl/kss_csr.sv
// Configuration registers of the Kalman smoother: process and measurement noise.
// APB-style access with no wait states. Depends on kss_pkg.
module kss_csr import kss_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output logic [REG_W-1:0]      process_noise,
   output logic [REG_W-1:0]      measure_noise
);

   logic [REG_W-1:0]  q_ff, q_in;
   logic [REG_W-1:0]  r_ff, r_in;
   kss_reg_index_type index;
   logic              wr_en;

   assign index = kss_reg_index_type'(paddr[CSR_ADDR_W-1]);
   assign wr_en = psel && penable && pwrite;

   always_comb begin
      q_in = q_ff;
      r_in = r_ff;
      if (wr_en) begin
         unique case (index)
            REG_PROCESS_NOISE: q_in = pwdata[REG_W-1:0];
            REG_MEASURE_NOISE: r_in = pwdata[REG_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         REG_PROCESS_NOISE: prdata = CSR_DATA_W'(q_ff);
         REG_MEASURE_NOISE: prdata = CSR_DATA_W'(r_ff);
         default:           prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_ff <= Q_RESET;
         r_ff <= R_RESET;
      end else begin
         q_ff <= q_in;
         r_ff <= r_in;
      end
   end

   assign pready        = 1'b1;
   assign process_noise = q_ff;
   assign measure_noise = r_ff;

endmodule

>>> rtl/kss_datapath.sv
// Datapath of the Kalman smoother: variance update, restoring gain divider,
// one shared multiplier, estimate store and the result register. Depends on kss_pkg.
module kss_datapath import kss_pkg::*; #(
   parameter int AXES      = DEF_AXES,
   parameter int FRAC_BITS = DEF_FRAC_BITS
) (
   input  logic               clock,
   input  logic               reset,
   input  kss_cmd_type        cmd,
   output kss_status_type     status,
   input  logic [REG_W-1:0]   process_noise,
   input  logic [REG_W-1:0]   measure_noise,
   input  kss_req_type        req_payload,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output kss_rsp_type        rsp_payload
);

   localparam int EST_W  = SAMPLE_W + FRAC_BITS + 1;
   localparam int DIFF_W = EST_W + 1;
   localparam int MAG_W  = EST_W;
   localparam int K_W    = FRAC_BITS + 1;
   localparam int PROD_W = VAR_W + K_W;
   localparam int REM_W  = DEN_W + 1;
   localparam int RND_W  = EST_W + 1 - FRAC_BITS;

   localparam logic [K_W-1:0]    K_ONE     = {1'b1, {FRAC_BITS{1'b0}}};
   localparam logic [VAR_W-1:0]  VAR_ONE   = VAR_W'(K_ONE);
   localparam logic [PROD_W-1:0] HALF_PROD = PROD_W'(1) << (FRAC_BITS - 1);
   localparam logic signed [EST_W:0]     HALF_EST = (EST_W + 1)'(1) << (FRAC_BITS - 1);
   localparam logic signed [RND_W-1:0]   RND_MAX  = RND_W'((2 ** (SAMPLE_W - 1)) - 1);
   localparam logic signed [RND_W-1:0]   RND_MIN  = -RND_MAX - RND_W'(1);

   logic [VAR_W-1:0]           p_ff, p_in;
   logic [VAR_W-1:0]           pp_ff;
   logic [DEN_W-1:0]           den_ff;
   logic                       den_zero_ff;
   logic [REM_W-1:0]           rem_ff;
   logic [K_W-1:0]             quo_ff;
   logic [PROD_W-1:0]          prod_ff;
   logic [K_W-1:0]             lo_term_ff;
   logic [MAG_W-1:0]           mag_ff;
   logic                       neg_ff;
   logic [SAMPLE_W-1:0]        z_ff [0:AXES-1];
   logic signed [EST_W-1:0]    est_ff [0:AXES-1];
   logic                       rsp_valid_ff, rsp_valid_in;
   kss_rsp_type                rsp_ff, rsp_in;

   logic [SAMPLE_W-1:0]        samples [0:NUM_FIELDS-1];
   logic [SAMPLE_W-1:0]        out_vals [0:NUM_FIELDS-1];
   logic [VAR_W:0]             pp_sum;
   logic [VAR_W-1:0]           pp_sat;
   logic [DEN_W-1:0]           den_sum;
   logic                       rem_ge;
   logic [REM_W-1:0]           rem_sub;
   logic [K_W-1:0]             k_val;
   logic [VAR_W-1:0]           mul_a;
   logic [K_W-1:0]             mul_b;
   logic [PROD_W-1:0]          mul_prod;
   logic [PROD_W-1:0]          prod_round;
   logic [DIFF_W-1:0]          diff;
   logic [PROD_W-1:0]          delta_sum;
   logic [EST_W-1:0]           delta;
   logic signed [EST_W-1:0]    est_new;

   function automatic logic [SAMPLE_W-1:0] round_sat(input logic signed [EST_W-1:0] x);
      logic signed [EST_W:0]   y;
      logic signed [RND_W-1:0] r;
      y = $signed({x[EST_W-1], x}) + HALF_EST;
      // Dropping the fraction of a two's complement value floors it.
      r = $signed(y[EST_W:FRAC_BITS]);
      if (r > RND_MAX) begin
         return RND_MAX[SAMPLE_W-1:0];
      end else if (r < RND_MIN) begin
         return RND_MIN[SAMPLE_W-1:0];
      end
      return r[SAMPLE_W-1:0];
   endfunction

   always_comb begin
      samples[0] = req_payload.accel_x;
      samples[1] = req_payload.accel_y;
      samples[2] = req_payload.accel_z;
      samples[3] = req_payload.gyro_x;
      samples[4] = req_payload.gyro_y;
      samples[5] = req_payload.gyro_z;
   end

   // Predicted variance, saturated to the width of the variance register.
   assign pp_sum  = {1'b0, p_ff} + (VAR_W + 1)'(process_noise);
   assign pp_sat  = pp_sum[VAR_W] ? '1 : pp_sum[VAR_W-1:0];
   assign den_sum = DEN_W'(pp_ff) + DEN_W'(measure_noise);

   // One quotient bit per step; the remainder starts at p' since the gain is at most one.
   assign rem_ge  = rem_ff >= REM_W'(den_ff);
   assign rem_sub = rem_ge ? rem_ff - REM_W'(den_ff) : rem_ff;
   assign k_val   = den_zero_ff ? '0 : quo_ff;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      if (cmd.var_mul) begin
         mul_a = pp_ff;
         mul_b = K_ONE - k_val;
      end else if (cmd.ax_mul_lo) begin
         mul_a = VAR_W'(mag_ff[FRAC_BITS-1:0]);
         mul_b = k_val;
      end else if (cmd.ax_mul_hi) begin
         mul_a = VAR_W'(mag_ff[MAG_W-1:FRAC_BITS]);
         mul_b = k_val;
      end
   end

   assign mul_prod   = PROD_W'(mul_a) * PROD_W'(mul_b);
   assign prod_round = prod_ff + HALF_PROD;

   assign diff = {{(DIFF_W - SAMPLE_W - FRAC_BITS){z_ff[0][SAMPLE_W-1]}}, z_ff[0],
                  {FRAC_BITS{1'b0}}} - {est_ff[0][EST_W-1], est_ff[0]};

   // The high partial product sits in prod_ff, the rounded low one in lo_term_ff.
   assign delta_sum = prod_ff + PROD_W'(lo_term_ff);
   assign delta     = delta_sum[EST_W-1:0];
   assign est_new   = neg_ff ? est_ff[0] - $signed(delta) : est_ff[0] + $signed(delta);

   assign p_in = cmd.var_wr ? prod_round[FRAC_BITS +: VAR_W] : p_ff;

   for (genvar g = 0; g < NUM_FIELDS; g++) begin : g_out
      if (g < AXES) begin : g_used
         assign out_vals[g] = round_sat(est_ff[g]);
      end else begin : g_unused
         assign out_vals[g] = '0;
      end
   end

   always_comb begin
      rsp_in.est_accel_x = out_vals[0];
      rsp_in.est_accel_y = out_vals[1];
      rsp_in.est_accel_z = out_vals[2];
      rsp_in.est_gyro_x  = out_vals[3];
      rsp_in.est_gyro_y  = out_vals[4];
      rsp_in.est_gyro_z  = out_vals[5];
   end

   assign rsp_valid_in    = cmd.publish || (rsp_valid_ff && rsp_stall);
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   // Filter state and the result valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         p_ff         <= VAR_ONE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < AXES; i++) begin
            est_ff[i] <= '0;
         end
      end else begin
         p_ff         <= p_in;
         rsp_valid_ff <= rsp_valid_in;
         // Each axis update rotates the store so the next axis sits at the head.
         if (cmd.ax_acc) begin
            for (int i = 0; i < AXES - 1; i++) begin
               est_ff[i] <= est_ff[i+1];
            end
            est_ff[AXES-1] <= est_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         pp_ff <= pp_sat;
         for (int i = 0; i < AXES; i++) begin
            z_ff[i] <= samples[i];
         end
      end else if (cmd.ax_acc) begin
         for (int i = 0; i < AXES - 1; i++) begin
            z_ff[i] <= z_ff[i+1];
         end
         z_ff[AXES-1] <= z_ff[0];
      end
      if (cmd.div_init) begin
         den_ff      <= den_sum;
         den_zero_ff <= den_sum == '0;
         rem_ff      <= REM_W'(pp_ff);
         quo_ff      <= '0;
      end else if (cmd.div_step) begin
         rem_ff <= {rem_sub[REM_W-2:0], 1'b0};
         quo_ff <= {quo_ff[K_W-2:0], rem_ge};
      end
      if (cmd.var_mul || cmd.ax_mul_lo || cmd.ax_mul_hi) begin
         prod_ff <= mul_prod;
      end
      if (cmd.ax_mul_hi) begin
         lo_term_ff <= prod_round[FRAC_BITS +: K_W];
      end
      if (cmd.ax_diff) begin
         neg_ff <= diff[DIFF_W-1];
         mag_ff <= diff[DIFF_W-1] ? MAG_W'(-diff) : MAG_W'(diff);
      end
      if (cmd.publish) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_gain_bounded: assert property (@(posedge clock) disable iff (reset)
      cmd.var_mul |-> k_val <= K_ONE)
      else $error("gain exceeds one");

   a_rem_bounded: assert property (@(posedge clock) disable iff (reset)
      (cmd.div_step && den_ff != '0) |-> rem_ff < {den_ff, 1'b0})
      else $error("divider remainder out of range");

   a_var_shrinks: assert property (@(posedge clock) disable iff (reset)
      cmd.var_wr |=> p_ff <= $past(pp_ff))
      else $error("updated variance exceeds the predicted variance");

endmodule

>>> rtl/kss_ctrl.sv
// Sequencer of the Kalman smoother: steps the datapath through the divide,
// the variance update and the per-axis updates. Depends on kss_pkg.
module kss_ctrl import kss_pkg::*; #(
   parameter int AXES      = DEF_AXES,
   parameter int FRAC_BITS = DEF_FRAC_BITS
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   input  kss_status_type status,
   output kss_cmd_type    cmd
);

   localparam int STEP_W = $clog2(FRAC_BITS + 1);
   localparam int AXC_W  = $clog2(AXES + 1);

   typedef enum logic [9:0] {
      ST_IDLE      = 10'b0000000001,
      ST_DIV_INIT  = 10'b0000000010,
      ST_DIV_STEP  = 10'b0000000100,
      ST_VAR_MUL   = 10'b0000001000,
      ST_VAR_WR    = 10'b0000010000,
      ST_AX_DIFF   = 10'b0000100000,
      ST_AX_MUL_LO = 10'b0001000000,
      ST_AX_MUL_HI = 10'b0010000000,
      ST_AX_ACC    = 10'b0100000000,
      ST_PUBLISH   = 10'b1000000000
   } kss_state_type;

   kss_state_type     state_ff, state_in;
   logic [STEP_W-1:0] step_cnt_ff, step_cnt_in;
   logic [AXC_W-1:0]  axis_cnt_ff, axis_cnt_in;
   logic              accept;

   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign req_stall = state_ff != ST_IDLE;

   always_comb begin
      state_in    = state_ff;
      step_cnt_in = step_cnt_ff;
      axis_cnt_in = axis_cnt_ff;
      cmd         = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DIV_INIT;
            end
         end
         ST_DIV_INIT: begin
            cmd.div_init = 1'b1;
            step_cnt_in  = '0;
            state_in     = ST_DIV_STEP;
         end
         ST_DIV_STEP: begin
            cmd.div_step = 1'b1;
            if (step_cnt_ff == STEP_W'(FRAC_BITS)) begin
               state_in = ST_VAR_MUL;
            end else begin
               step_cnt_in = step_cnt_ff + STEP_W'(1);
            end
         end
         ST_VAR_MUL: begin
            cmd.var_mul = 1'b1;
            state_in    = ST_VAR_WR;
         end
         ST_VAR_WR: begin
            cmd.var_wr  = 1'b1;
            axis_cnt_in = '0;
            state_in    = ST_AX_DIFF;
         end
         ST_AX_DIFF: begin
            cmd.ax_diff = 1'b1;
            state_in    = ST_AX_MUL_LO;
         end
         ST_AX_MUL_LO: begin
            cmd.ax_mul_lo = 1'b1;
            state_in      = ST_AX_MUL_HI;
         end
         ST_AX_MUL_HI: begin
            cmd.ax_mul_hi = 1'b1;
            state_in      = ST_AX_ACC;
         end
         ST_AX_ACC: begin
            cmd.ax_acc = 1'b1;
            if (axis_cnt_ff == AXC_W'(AXES - 1)) begin
               state_in = ST_PUBLISH;
            end else begin
               axis_cnt_in = axis_cnt_ff + AXC_W'(1);
               state_in    = ST_AX_DIFF;
            end
         end
         ST_PUBLISH: begin
            // Hold the finished result until the output register is free.
            if (status.out_free) begin
               cmd.publish = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         step_cnt_ff <= '0;
         axis_cnt_ff <= '0;
      end else begin
         state_ff    <= state_in;
         step_cnt_ff <= step_cnt_in;
         axis_cnt_ff <= axis_cnt_in;
      end
   end

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_DIV_INIT)
      else $error("accepted beat did not start the divide");

   a_publish_free: assert property (@(posedge clock) disable iff (reset)
      cmd.publish |-> status.out_free)
      else $error("result published over a waiting result");

   a_full_divide: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_VAR_MUL) |->
         ($past(state_ff) == ST_DIV_STEP && $past(step_cnt_ff) == STEP_W'(FRAC_BITS)))
      else $error("gain used before all quotient bits were produced");

endmodule

>>> rtl/six_axis_scalar_kalman_smoother_unit.sv
// Six-axis scalar Kalman smoother: random-walk model with one shared variance.
// Request beats carry six 16-bit IMU samples, response beats six filtered samples.
// Both channels use valid/stall; a beat moves when valid is high and stall is low.
// Noise variances are set through the APB-style port: process noise at byte
// address 0, measurement noise at byte address 4, 16 fraction bits each.
// One response beat follows every request beat. The restoring gain divider
// yields one quotient bit per cycle; then each axis takes a difference, a low
// product, a high product and an accumulate step on the single shared
// multiplier. The block takes no new request until the previous result is
// published and it is idle again; req_stall is high while an
// item is in work. A finished result waits in the output register while the
// receiver stalls; the next request is still taken, and its result is held
// back until the output register empties. Reset clears the estimates to zero,
// the error variance to 1.0 and the noise registers to 0.01 and 0.1.
// Depends on kss_pkg, kss_csr, kss_ctrl and kss_datapath.
module six_axis_scalar_kalman_smoother_unit import kss_pkg::*; #(
   parameter int AXES      = DEF_AXES,
   parameter int FRAC_BITS = DEF_FRAC_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  kss_req_type           req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output kss_rsp_type           rsp_payload,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   logic [REG_W-1:0] process_noise;
   logic [REG_W-1:0] measure_noise;
   kss_cmd_type      cmd;
   kss_status_type   status;

   kss_csr u_csr (
      .clock         (clock),
      .reset         (reset),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready),
      .process_noise (process_noise),
      .measure_noise (measure_noise)
   );

   kss_ctrl #(
      .AXES      (AXES),
      .FRAC_BITS (FRAC_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   kss_datapath #(
      .AXES      (AXES),
      .FRAC_BITS (FRAC_BITS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .process_noise (process_noise),
      .measure_noise (measure_noise),
      .req_payload   (req_payload),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_payload   (rsp_payload)
   );

endmodule

>>> tb/sv/tb_six_axis_scalar_kalman_smoother_unit.sv
// Self-checking testbench for six_axis_scalar_kalman_smoother_unit: random-walk gain,
// shared error variance, rounded and saturated estimates, checked beat by beat.
// Depends on kss_pkg and the smoother RTL; needs no files or arguments.
module tb_six_axis_scalar_kalman_smoother_unit;
   import kss_pkg::*;

   localparam int FRAC = DEF_FRAC_BITS;
   localparam longint unsigned ONE = 64'd1 << FRAC;
   localparam longint unsigned VAR_LIMIT = (64'd1 << VAR_W) - 1;
   localparam logic [REG_W-1:0] REG_MAX = {REG_W{1'b1}};
   localparam int MAX_GAP = 18;
   localparam int LATENCY = DEF_FRAC_BITS + 4 * DEF_AXES + 6;
   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_ITEMS = 850;
   localparam int PHASES = 8;
   localparam int FW = SAMPLE_W * NUM_FIELDS;

   logic clock = 1'b0;
   logic reset;
   logic req_valid;
   logic req_stall;
   kss_req_type req_payload;
   logic rsp_valid;
   logic rsp_stall;
   kss_rsp_type rsp_payload;
   logic psel;
   logic penable;
   logic pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic pready;

   // Predictor state.
   longint axis_estimate [NUM_FIELDS];
   longint unsigned shared_variance;
   longint unsigned q_noise;
   longint unsigned r_noise;
   kss_rsp_type pending_estimates [$];

   int last_z [NUM_FIELDS];
   int mismatches = 0;
   int cycle_count = 0;
   int beats_sent = 0;
   int beats_taken = 0;
   bit send_calm = 1'b0;
   bit take_calm = 1'b0;
   bit reset_done = 1'b0;

   string field_names [NUM_FIELDS] = '{"est_accel_x", "est_accel_y", "est_accel_z",
                                        "est_gyro_x", "est_gyro_y", "est_gyro_z"};

   six_axis_scalar_kalman_smoother_unit u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // One filter update over all six axes; returns the rounded estimates.
   function automatic kss_rsp_type smooth_step(kss_req_type s);
      longint unsigned pp;
      longint unsigned den;
      longint unsigned gain;
      longint unsigned mag;
      longint unsigned step_mag;
      longint diff;
      longint rounded;
      logic signed [SAMPLE_W-1:0] z [NUM_FIELDS];
      logic [FW-1:0] flat;
      pp = shared_variance + q_noise;
      if (pp > VAR_LIMIT) pp = VAR_LIMIT;
      den = pp + r_noise;
      gain = (den == 0) ? 0 : (pp << FRAC) / den;
      if (gain > ONE) gain = ONE;
      shared_variance = ((ONE - gain) * pp + (ONE >> 1)) >> FRAC;
      if (shared_variance > VAR_LIMIT) shared_variance = VAR_LIMIT;
      z[0] = s.accel_x;
      z[1] = s.accel_y;
      z[2] = s.accel_z;
      z[3] = s.gyro_x;
      z[4] = s.gyro_y;
      z[5] = s.gyro_z;
      for (int i = 0; i < NUM_FIELDS; i++) begin
         diff = (longint'(z[i]) <<< FRAC) - axis_estimate[i];
         mag = (diff < 0) ? -diff : diff;
         // Split the magnitude so the product stays exact; the rounding is on the
         // fraction part only, half away from zero once the sign is put back.
         step_mag = (mag >> FRAC) * gain + (((mag & (ONE - 1)) * gain + (ONE >> 1)) >> FRAC);
         if (diff < 0) axis_estimate[i] -= longint'(step_mag);
         else axis_estimate[i] += longint'(step_mag);
         rounded = (axis_estimate[i] + longint'(ONE >> 1)) >>> FRAC;
         if (rounded > 32767) rounded = 32767;
         if (rounded < -32768) rounded = -32768;
         flat[SAMPLE_W*(NUM_FIELDS-1-i) +: SAMPLE_W] = rounded[SAMPLE_W-1:0];
      end
      return kss_rsp_type'(flat);
   endfunction

   function automatic kss_req_type make_sample(int ax, int ay, int az, int gx, int gy, int gz);
      kss_req_type s;
      s.accel_x = SAMPLE_W'(ax);
      s.accel_y = SAMPLE_W'(ay);
      s.accel_z = SAMPLE_W'(az);
      s.gyro_x = SAMPLE_W'(gx);
      s.gyro_y = SAMPLE_W'(gy);
      s.gyro_z = SAMPLE_W'(gz);
      return s;
   endfunction

   // Mostly a slow random walk, as a real sensor gives, with jumps and rail values.
   function automatic kss_req_type random_sample();
      int v [NUM_FIELDS];
      int kind;
      for (int i = 0; i < NUM_FIELDS; i++) begin
         kind = $urandom_range(0, 99);
         if (kind < 60) begin
            v[i] = last_z[i] + int'($urandom_range(0, 512)) - 256;
            if (v[i] > 32767) v[i] = 32767;
            if (v[i] < -32768) v[i] = -32768;
         end else if (kind < 85) begin
            v[i] = int'($urandom_range(0, 65535)) - 32768;
         end else begin
            case ($urandom_range(0, 4))
               0: v[i] = 32767;
               1: v[i] = -32768;
               2: v[i] = 0;
               3: v[i] = -1;
               default: v[i] = int'($urandom_range(0, 65535)) - 32768;
            endcase
         end
         last_z[i] = v[i];
      end
      return make_sample(v[0], v[1], v[2], v[3], v[4], v[5]);
   endfunction

   task automatic note_mismatch(string what, logic [FW-1:0] want, logic [FW-1:0] got);
      mismatches++;
      if (mismatches <= 10)
         $display("mismatch at cycle %0d, %s: expected %0h, got %0h", cycle_count, what, want, got);
   endtask

   task automatic check_estimate(kss_rsp_type got);
      kss_rsp_type want;
      logic [FW-1:0] w;
      logic [FW-1:0] g;
      if (pending_estimates.size() == 0) begin
         note_mismatch("response beat with nothing pending", '0, got);
      end else begin
         want = pending_estimates.pop_front();
         w = want;
         g = got;
         for (int i = 0; i < NUM_FIELDS; i++) begin
            if (g[SAMPLE_W*(NUM_FIELDS-1-i) +: SAMPLE_W] !== w[SAMPLE_W*(NUM_FIELDS-1-i) +: SAMPLE_W])
               note_mismatch(field_names[i], w[SAMPLE_W*(NUM_FIELDS-1-i) +: SAMPLE_W],
                             g[SAMPLE_W*(NUM_FIELDS-1-i) +: SAMPLE_W]);
         end
      end
   endtask

   // Receiver: a fresh stall length for every beat, with calm stretches.
   initial begin
      int gap;
      wait (reset_done);
      @(negedge clock);
      forever begin
         if (beats_taken % 16 == 0) take_calm = ($urandom_range(0, 2) == 0);
         gap = take_calm ? 0 : $urandom_range(0, MAX_GAP);
         if (gap != 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         check_estimate(rsp_payload);
         beats_taken++;
         @(negedge clock);
      end
   end

   // Called and returns at a falling edge; valid is left high for the next beat.
   task automatic send_sample(kss_req_type s);
      int gap;
      if (beats_sent % 32 == 0) send_calm = ($urandom_range(0, 2) == 0);
      gap = send_calm ? 0 : $urandom_range(0, MAX_GAP);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_payload <= s;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_estimates.push_back(smooth_step(s));
      beats_sent++;
      @(negedge clock);
   endtask

   task automatic wait_quiet();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_estimates.size() != 0 || req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   // Returns with the bus idle: psel and penable are dropped after each access.
   task automatic csr_access(kss_reg_index_type idx, bit wr, logic [CSR_DATA_W-1:0] wdata,
                             output logic [CSR_DATA_W-1:0] rdata);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= wr;
      paddr <= CSR_ADDR_W'({idx, 2'b00});
      pwdata <= wdata;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      rdata = prdata;
      if (wr) begin
         if (idx == REG_PROCESS_NOISE) q_noise = wdata[REG_W-1:0];
         else r_noise = wdata[REG_W-1:0];
      end
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(negedge clock);
   endtask

   task automatic check_csr(kss_reg_index_type idx, logic [REG_W-1:0] want);
      logic [CSR_DATA_W-1:0] rdata;
      csr_access(idx, 1'b0, '0, rdata);
      if (rdata !== CSR_DATA_W'(want))
         note_mismatch(idx == REG_PROCESS_NOISE ? "process_noise read" : "measure_noise read",
                       FW'(want), FW'(rdata));
   endtask

   // Only while idle; the upper bus bits carry junk that the register must drop.
   task automatic set_noise(logic [REG_W-1:0] q, logic [REG_W-1:0] r);
      logic [CSR_DATA_W-1:0] unused;
      wait_quiet();
      csr_access(REG_PROCESS_NOISE, 1'b1, {8'($urandom), q}, unused);
      csr_access(REG_MEASURE_NOISE, 1'b1, {8'($urandom), r}, unused);
      check_csr(REG_PROCESS_NOISE, q);
      check_csr(REG_MEASURE_NOISE, r);
   endtask

   task automatic test_reset_values();
      check_csr(REG_PROCESS_NOISE, Q_RESET);
      check_csr(REG_MEASURE_NOISE, R_RESET);
      send_sample(make_sample(32767, 32767, 32767, 32767, 32767, 32767));
      send_sample(make_sample(-32768, -32768, -32768, -32768, -32768, -32768));
      send_sample(make_sample(32767, -32768, 32767, -32768, 32767, -32768));
      send_sample(make_sample(0, 0, 0, 0, 0, 0));
   endtask

   task automatic test_bit_patterns();
      send_sample(make_sample(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA));
      send_sample(make_sample(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555));
      send_sample(make_sample(-1, 1, -1, 1, -1, 1));
      send_sample(make_sample(1, -1, 1, -1, 1, -1));
   endtask

   // With no measurement noise the first beat takes the samples outright and
   // drives the variance to zero; with no process noise either, the total
   // variance is then zero and the estimates must hold.
   task automatic test_zero_noise();
      set_noise('0, '0);
      send_sample(make_sample(1234, -4321, 32767, -32768, 7, -7));
      send_sample(make_sample(-32768, 32767, 0, 100, -100, 5000));
      send_sample(make_sample(0, 0, 0, 0, 0, 0));
      send_sample(make_sample(32767, 32767, -32768, -32768, 1, -1));
   endtask

   task automatic test_variance_extremes();
      set_noise(REG_MAX, REG_MAX);
      send_sample(make_sample(32767, -32768, 100, -100, 32767, -32768));
      send_sample(make_sample(-32768, 32767, -100, 100, -32768, 32767));
      send_sample(make_sample(0, 0, 0, 0, 0, 0));
      set_noise(REG_MAX, REG_W'(1));
      send_sample(make_sample(20000, -20000, 3, -3, 32767, -32768));
      send_sample(make_sample(-20000, 20000, -3, 3, -32768, 32767));
      send_sample(make_sample(1, 1, 1, 1, 1, 1));
      set_noise('0, REG_MAX);
      send_sample(make_sample(32767, 32767, 32767, -32768, -32768, -32768));
      send_sample(make_sample(-32768, -32768, -32768, 32767, 32767, 32767));
      send_sample(make_sample(32767, 32767, 32767, -32768, -32768, -32768));
   endtask

   function automatic logic [REG_W-1:0] pick_noise(bit measure);
      case ($urandom_range(0, 5))
         0: return measure ? REG_W'($urandom_range(0, 1)) : '0;
         1: return REG_MAX;
         2: return measure ? R_RESET : Q_RESET;
         3: return REG_W'($urandom_range(1, 4095));
         4: return REG_W'($urandom_range(4096, 1 << 20));
         default: return REG_W'($urandom);
      endcase
   endfunction

   task automatic test_random_phases();
      for (int p = 0; p < PHASES; p++) begin
         set_noise(pick_noise(1'b0), pick_noise(1'b1));
         repeat (RANDOM_ITEMS / PHASES) send_sample(random_sample());
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      rsp_stall = 1'b0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      for (int i = 0; i < NUM_FIELDS; i++) begin
         axis_estimate[i] = 0;
         last_z[i] = 0;
      end
      shared_variance = ONE;
      q_noise = Q_RESET;
      r_noise = R_RESET;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      reset_done = 1'b1;

      test_reset_values();
      test_bit_patterns();
      test_zero_noise();
      test_variance_extremes();
      test_random_phases();

      wait_quiet();
      // Anything the block still produces now has no expectation and fails.
      repeat (LATENCY + 4) @(posedge clock);
      if (mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

>>> sim.f
rtl/kss_pkg.sv
rtl/kss_csr.sv
rtl/kss_datapath.sv
rtl/kss_ctrl.sv
rtl/six_axis_scalar_kalman_smoother_unit.sv
tb/sv/tb_six_axis_scalar_kalman_smoother_unit.sv
